// ===== rtl/traffic_light_sequencer_assert.svh =====
// Assertion macros for the traffic light sequencer.
`ifndef TRAFFIC_LIGHT_SEQUENCER_ASSERT_SVH
`define TRAFFIC_LIGHT_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF

`define TLS_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("traffic light sequencer: assertion failed");

`define TLS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("traffic light sequencer: assertion failed");

`else

`define TLS_ASSERT_IMPL(label, clk, rst_n, cond, prop)
`define TLS_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== rtl/tls_pkg.sv =====
package tls_pkg;

    localparam int unsigned NOW_W      = 32;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned PDATA_W    = 32;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd800;

    // register indexes (word address)
    localparam logic [PADDR_W-3:0] REG_STEP_INTERVAL = 1'b0;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_GREEN   = 2'd1,
        MODE_RED     = 2'd2,
        MODE_DISABLE = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        PH_DARK  = 4'd0,
        PH_RED   = 4'd1,
        PH_R2G_0 = 4'd2,
        PH_R2G_1 = 4'd3,
        PH_R2G_2 = 4'd4,
        PH_GREEN = 4'd5,
        PH_G2R_0 = 4'd6,
        PH_G2R_1 = 4'd7,
        PH_G2R_2 = 4'd8,
        PH_BLINK = 4'd9
    } phase_t;

    typedef struct packed {
        mode_t             mode;
        logic [NOW_W-1:0]  now_ms;
    } item_t;

    typedef struct packed {
        logic   red;
        logic   yellow;
        logic   green;
        phase_t phase;
    } result_t;

    function automatic phase_t next_phase(phase_t p);
        phase_t n;
        case (p)
            PH_DARK:  n = PH_BLINK;
            PH_RED:   n = PH_RED;
            PH_R2G_0: n = PH_R2G_1;
            PH_R2G_1: n = PH_R2G_2;
            PH_R2G_2: n = PH_GREEN;
            PH_GREEN: n = PH_GREEN;
            PH_G2R_0: n = PH_G2R_1;
            PH_G2R_1: n = PH_G2R_2;
            PH_G2R_2: n = PH_RED;
            PH_BLINK: n = PH_DARK;
            default:  n = PH_DARK;
        endcase
        return n;
    endfunction

    // lamps as {red, yellow, green}
    function automatic logic [2:0] lamps_of(phase_t p);
        logic [2:0] l;
        case (p)
            PH_RED, PH_R2G_0, PH_G2R_2:     l = 3'b100;
            PH_R2G_1:                       l = 3'b110;
            PH_R2G_2, PH_GREEN, PH_G2R_0:   l = 3'b001;
            PH_G2R_1, PH_BLINK:             l = 3'b010;
            default:                        l = 3'b000;
        endcase
        return l;
    endfunction

endpackage

// ===== rtl/traffic_light_sequencer.sv =====
// Traffic light sequencer.
// Input channel (in_valid/in_ready): mode and now_ms. Mode 0 is a tick that
// carries a millisecond timestamp; modes 1..3 request green, red or disable.
// Output channel (out_valid/out_ready): one lamp/phase item per tick, none
// per request. Configuration: APB port, step_interval_ms at address 0.
// Path: an accepted item lands in the input register and is processed from
// there; a tick's result is then loaded into the output register, which
// drives out_valid, unless a stall holds the tick in the input register.
// Throughput: one item per cycle unless a held tick stalls; phase update is
// a combinational 32-bit subtract, compare and ten-entry phase table.
// Reset: phase goes dark (0), the last-change time clears, the interval
// returns to 800 ms, and both channel registers are emptied.
// Stall: while a result waits unaccepted, requests keep flowing; a tick is
// held in the input register until the output register frees up, and
// in_ready drops once the input register is full behind it.
`include "traffic_light_sequencer_assert.svh"

module traffic_light_sequencer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tls_pkg::PADDR_W-1:0]         paddr,
    input  logic [tls_pkg::PDATA_W-1:0]         pwdata,
    output logic [tls_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic [tls_pkg::NOW_W-1:0]           now_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                red_lamp,
    output logic                                yellow_lamp,
    output logic                                green_lamp,
    output logic [3:0]                          phase_now
);

    logic [tls_pkg::INTERVAL_W-1:0] step_interval;

    logic               in_valid_reg;
    logic               in_valid_next;
    tls_pkg::item_t     in_item_reg;
    tls_pkg::item_t     in_item_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    tls_pkg::result_t   out_res_reg;
    tls_pkg::result_t   out_res_next;
    tls_pkg::result_t   core_res;
    tls_pkg::phase_t    core_phase;
    logic               is_tick;
    logic               go;

    tls_apb_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .step_interval (step_interval)
    );

    tls_phase_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (go),
        .item          (in_item_reg),
        .step_interval (step_interval),
        .res           (core_res),
        .phase         (core_phase)
    );

    assign is_tick  = (in_item_reg.mode == tls_pkg::MODE_TICK);
    // requests never need the output register
    assign go       = in_valid_reg && (!is_tick || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || go;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
            in_item_next  = '{mode: tls_pkg::mode_t'(mode), now_ms: now_ms};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (go && is_tick)
        begin
            out_valid_next = 1'b1;
            out_res_next   = core_res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign red_lamp    = out_res_reg.red;
    assign yellow_lamp = out_res_reg.yellow;
    assign green_lamp  = out_res_reg.green;
    assign phase_now   = out_res_reg.phase;

    // phase never leaves the ten defined codes
    `TLS_ASSERT_IMPL(a_phase_range, clk, rst_n, 1'b1, core_phase <= tls_pkg::PH_BLINK)
    // a processed tick shows up as the held phase on the output register
    `TLS_ASSERT_NEXT(a_tick_valid, clk, rst_n, go && is_tick, out_valid_reg)
    `TLS_ASSERT_NEXT(a_tick_phase, clk, rst_n, go && is_tick, out_res_reg.phase == core_phase)
    // a request never creates a result
    `TLS_ASSERT_NEXT(a_req_no_result, clk, rst_n, go && !is_tick && !out_valid_reg, !out_valid_reg)
    // an empty input register always takes an item
    `TLS_ASSERT_IMPL(a_in_room, clk, rst_n, !in_valid_reg, in_ready)

endmodule

// ===== rtl/tls_apb_regs.sv =====
module tls_apb_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tls_pkg::PADDR_W-1:0]         paddr,
    input  logic [tls_pkg::PDATA_W-1:0]         pwdata,
    output logic [tls_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    output logic [tls_pkg::INTERVAL_W-1:0]      step_interval
);

    logic [tls_pkg::INTERVAL_W-1:0] interval_reg;
    logic [tls_pkg::INTERVAL_W-1:0] interval_next;
    logic                           sel_interval;

    assign pready        = 1'b1;
    assign sel_interval  = (paddr[tls_pkg::PADDR_W-1:2] == tls_pkg::REG_STEP_INTERVAL);
    assign step_interval = interval_reg;

    always_comb
    begin
        interval_next = interval_reg;
        if (psel && penable && pwrite && sel_interval)
        begin
            interval_next = pwdata[tls_pkg::INTERVAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= tls_pkg::INTERVAL_RESET;
        end
        else
        begin
            interval_reg <= interval_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_interval)
        begin
            prdata = {{(tls_pkg::PDATA_W-tls_pkg::INTERVAL_W){1'b0}}, interval_reg};
        end
    end

endmodule

// ===== rtl/tls_phase_core.sv =====
module tls_phase_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  tls_pkg::item_t                  item,
    input  logic [tls_pkg::INTERVAL_W-1:0]  step_interval,
    output tls_pkg::result_t                res,
    output tls_pkg::phase_t                 phase
);

    tls_pkg::phase_t                phase_reg;
    tls_pkg::phase_t                phase_next;
    logic [tls_pkg::NOW_W-1:0]      last_reg;
    logic [tls_pkg::NOW_W-1:0]      last_next;
    logic [tls_pkg::NOW_W-1:0]      elapsed;
    logic                           exceeded;
    logic                           to_green;
    logic                           to_red;
    logic                           to_dark;
    logic [2:0]                     lamps;

    // elapsed wraps modulo 2^32
    assign elapsed  = item.now_ms - last_reg;
    assign exceeded = elapsed > {{(tls_pkg::NOW_W-tls_pkg::INTERVAL_W){1'b0}}, step_interval};

    always_comb
    begin
        to_green = !(phase_reg inside {[tls_pkg::PH_R2G_0:tls_pkg::PH_GREEN]});
        to_red   = !(phase_reg inside {tls_pkg::PH_RED, [tls_pkg::PH_G2R_0:tls_pkg::PH_G2R_2]});
        to_dark  = !(phase_reg inside {tls_pkg::PH_DARK, tls_pkg::PH_BLINK});
    end

    always_comb
    begin
        phase_next = phase_reg;
        last_next  = last_reg;
        if (go)
        begin
            case (item.mode)
                tls_pkg::MODE_TICK:
                begin
                    if (exceeded)
                    begin
                        phase_next = tls_pkg::next_phase(phase_reg);
                        last_next  = item.now_ms;
                    end
                end
                tls_pkg::MODE_GREEN:
                begin
                    if (to_green)
                    begin
                        phase_next = tls_pkg::PH_R2G_0;
                        last_next  = '0;
                    end
                end
                tls_pkg::MODE_RED:
                begin
                    if (to_red)
                    begin
                        phase_next = tls_pkg::PH_G2R_0;
                        last_next  = '0;
                    end
                end
                tls_pkg::MODE_DISABLE:
                begin
                    if (to_dark)
                    begin
                        phase_next = tls_pkg::PH_DARK;
                        last_next  = '0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tls_pkg::PH_DARK;
            last_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            last_reg  <= last_next;
        end
    end

    // result reflects the phase after this tick
    assign lamps      = tls_pkg::lamps_of(phase_next);
    assign res.red    = lamps[2];
    assign res.yellow = lamps[1];
    assign res.green  = lamps[0];
    assign res.phase  = phase_next;
    assign phase      = phase_reg;

endmodule
